// ----- sv/mhe_pkg.sv -----
package mhe_pkg;

	localparam logic [31:0] INIT_A = 32'h67452301;
	localparam logic [31:0] INIT_B = 32'hefcdab89;
	localparam logic [31:0] INIT_C = 32'h98badcfe;
	localparam logic [31:0] INIT_D = 32'h10325476;

	// block byte position where the 64-bit length field starts
	localparam logic [5:0] LEN_POS = 6'd56;
	localparam logic [5:0] LAST_POS = 6'd63;
	localparam logic [7:0] PAD_MARK = 8'h80;

	// queue between packer and compressor: two block slots
	localparam int SLOTS = 2;
	localparam int SLOT_W = 1;
	localparam logic [1:0] SLOTS_FULL = 2'd2;

	typedef struct packed {
		logic        en;        // store one packed word
		logic [3:0]  idx;       // word index within the block
		logic [31:0] data;
		logic        commit;    // block complete, hand slot to compressor
		logic        last_blk;  // block closes a message
	} q_wr_t;

	typedef struct packed {
		logic [3:0] idx;        // word to read from the head block
		logic       pop;        // release the head block
	} q_rd_t;

	typedef struct packed {
		logic space;            // a slot is free for the packer
		logic avail;            // a full block waits at the head
		logic head_last;        // head block closes a message
	} q_stat_t;

	function automatic logic [31:0] k_const(input logic [5:0] i);
		logic [31:0] k;
		case (i)
			6'd0:  k = 32'hd76aa478;
			6'd1:  k = 32'he8c7b756;
			6'd2:  k = 32'h242070db;
			6'd3:  k = 32'hc1bdceee;
			6'd4:  k = 32'hf57c0faf;
			6'd5:  k = 32'h4787c62a;
			6'd6:  k = 32'ha8304613;
			6'd7:  k = 32'hfd469501;
			6'd8:  k = 32'h698098d8;
			6'd9:  k = 32'h8b44f7af;
			6'd10: k = 32'hffff5bb1;
			6'd11: k = 32'h895cd7be;
			6'd12: k = 32'h6b901122;
			6'd13: k = 32'hfd987193;
			6'd14: k = 32'ha679438e;
			6'd15: k = 32'h49b40821;
			6'd16: k = 32'hf61e2562;
			6'd17: k = 32'hc040b340;
			6'd18: k = 32'h265e5a51;
			6'd19: k = 32'he9b6c7aa;
			6'd20: k = 32'hd62f105d;
			6'd21: k = 32'h02441453;
			6'd22: k = 32'hd8a1e681;
			6'd23: k = 32'he7d3fbc8;
			6'd24: k = 32'h21e1cde6;
			6'd25: k = 32'hc33707d6;
			6'd26: k = 32'hf4d50d87;
			6'd27: k = 32'h455a14ed;
			6'd28: k = 32'ha9e3e905;
			6'd29: k = 32'hfcefa3f8;
			6'd30: k = 32'h676f02d9;
			6'd31: k = 32'h8d2a4c8a;
			6'd32: k = 32'hfffa3942;
			6'd33: k = 32'h8771f681;
			6'd34: k = 32'h6d9d6122;
			6'd35: k = 32'hfde5380c;
			6'd36: k = 32'ha4beea44;
			6'd37: k = 32'h4bdecfa9;
			6'd38: k = 32'hf6bb4b60;
			6'd39: k = 32'hbebfbc70;
			6'd40: k = 32'h289b7ec6;
			6'd41: k = 32'heaa127fa;
			6'd42: k = 32'hd4ef3085;
			6'd43: k = 32'h04881d05;
			6'd44: k = 32'hd9d4d039;
			6'd45: k = 32'he6db99e5;
			6'd46: k = 32'h1fa27cf8;
			6'd47: k = 32'hc4ac5665;
			6'd48: k = 32'hf4292244;
			6'd49: k = 32'h432aff97;
			6'd50: k = 32'hab9423a7;
			6'd51: k = 32'hfc93a039;
			6'd52: k = 32'h655b59c3;
			6'd53: k = 32'h8f0ccc92;
			6'd54: k = 32'hffeff47d;
			6'd55: k = 32'h85845dd1;
			6'd56: k = 32'h6fa87e4f;
			6'd57: k = 32'hfe2ce6e0;
			6'd58: k = 32'ha3014314;
			6'd59: k = 32'h4e0811a1;
			6'd60: k = 32'hf7537e82;
			6'd61: k = 32'hbd3af235;
			6'd62: k = 32'h2ad7d2bb;
			6'd63: k = 32'heb86d391;
			default: k = 32'h0;
		endcase
		return k;
	endfunction

	function automatic logic [4:0] rot_amt(input logic [5:0] i);
		logic [4:0] s;
		case ({i[5:4], i[1:0]})
			4'd0:  s = 5'd7;
			4'd1:  s = 5'd12;
			4'd2:  s = 5'd17;
			4'd3:  s = 5'd22;
			4'd4:  s = 5'd5;
			4'd5:  s = 5'd9;
			4'd6:  s = 5'd14;
			4'd7:  s = 5'd20;
			4'd8:  s = 5'd4;
			4'd9:  s = 5'd11;
			4'd10: s = 5'd16;
			4'd11: s = 5'd23;
			4'd12: s = 5'd6;
			4'd13: s = 5'd10;
			4'd14: s = 5'd15;
			4'd15: s = 5'd21;
			default: s = 5'd0;
		endcase
		return s;
	endfunction

	// message word used by each round step
	function automatic logic [3:0] msg_idx(input logic [5:0] i);
		logic [3:0] j;
		logic [3:0] g;
		j = i[3:0];
		case (i[5:4])
			2'd0: g = j;
			2'd1: g = j * 4'd5 + 4'd1;
			2'd2: g = j * 4'd3 + 4'd5;
			2'd3: g = j * 4'd7;
			default: g = j;
		endcase
		return g;
	endfunction

	function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
		logic [63:0] t;
		t = {x, x} << s;
		return t[63:32];
	endfunction

endpackage

// ----- sv/mhe_front.sv -----
module mhe_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,   // [7:0] data_byte
	input  logic                  s_tuser,   // [0] byte_present
	input  logic                  s_tlast,   // end_of_message
	input  mhe_pkg::q_stat_t      stat,
	output mhe_pkg::q_wr_t        wr
);

	typedef enum logic [1:0] {
		F_IN,
		F_MARK,
		F_ZERO,
		F_LEN
	} f_state_t;

	f_state_t     state_q;
	logic [5:0]   pos_q;
	logic [63:0]  len_q;
	logic [23:0]  word_q;

	logic         accept;
	logic         push_en;
	logic [7:0]   push_byte;

	assign s_tready = (state_q == F_IN) && stat.space;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		case (state_q)
			F_IN: begin
				push_en   = accept && s_tuser;
				push_byte = s_tdata;
			end
			F_MARK: begin
				push_en   = stat.space;
				push_byte = mhe_pkg::PAD_MARK;
			end
			F_ZERO: begin
				push_en   = stat.space;
				push_byte = 8'h00;
			end
			F_LEN: begin
				push_en   = stat.space;
				push_byte = len_q[{pos_q[2:0], 3'b000} +: 8];
			end
			default: begin
				push_en   = 1'b0;
				push_byte = 8'h00;
			end
		endcase
	end

	assign wr.en       = push_en && (pos_q[1:0] == 2'd3);
	assign wr.idx      = pos_q[5:2];
	assign wr.data     = {push_byte, word_q};
	assign wr.commit   = push_en && (pos_q == mhe_pkg::LAST_POS);
	assign wr.last_blk = (state_q == F_LEN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IN;
			pos_q   <= 6'd0;
			len_q   <= 64'd0;
		end else begin
			if (push_en) begin
				pos_q <= pos_q + 6'd1;
			end
			case (state_q)
				F_IN: begin
					if (accept) begin
						if (s_tuser) begin
							len_q <= len_q + 64'd8;
						end
						if (s_tlast) begin
							state_q <= F_MARK;
						end
					end
				end
				F_MARK, F_ZERO: begin
					if (push_en) begin
						state_q <= (pos_q == mhe_pkg::LEN_POS - 6'd1) ? F_LEN : F_ZERO;
					end
				end
				F_LEN: begin
					// last length byte closes the message
					if (push_en && (pos_q == mhe_pkg::LAST_POS)) begin
						state_q <= F_IN;
						len_q   <= 64'd0;
					end
				end
				default: begin
					state_q <= F_IN;
				end
			endcase
		end
	end

	// little-endian byte lanes of the word being packed
	always_ff @(posedge clk) begin
		if (push_en) begin
			case (pos_q[1:0])
				2'd0: word_q <= {16'h0000, push_byte};
				2'd1: word_q <= {8'h00, push_byte, word_q[7:0]};
				2'd2: word_q <= {push_byte, word_q[15:0]};
				default: word_q <= word_q;
			endcase
		end
	end

endmodule

// ----- sv/mhe_queue.sv -----
module mhe_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mhe_pkg::q_wr_t        wr,
	input  mhe_pkg::q_rd_t        rd,
	output mhe_pkg::q_stat_t      stat,
	output logic [31:0]           rdata
);

	logic [31:0]                 mem [mhe_pkg::SLOTS * 16];
	logic [mhe_pkg::SLOTS-1:0]   last_q;
	logic [1:0]                  count_q;
	logic [mhe_pkg::SLOT_W-1:0]  wr_slot_q;
	logic [mhe_pkg::SLOT_W-1:0]  rd_slot_q;
	logic [31:0]                 rdata_q;

	assign stat.space     = (count_q != mhe_pkg::SLOTS_FULL);
	assign stat.avail     = (count_q != 2'd0);
	assign stat.head_last = last_q[rd_slot_q];
	assign rdata          = rdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= 2'd0;
			wr_slot_q <= '0;
			rd_slot_q <= '0;
			last_q    <= '0;
		end else begin
			count_q <= count_q + {1'b0, wr.commit} - {1'b0, rd.pop};
			if (wr.commit) begin
				wr_slot_q         <= wr_slot_q + 1'b1;
				last_q[wr_slot_q] <= wr.last_blk;
			end
			if (rd.pop) begin
				rd_slot_q <= rd_slot_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[{wr_slot_q, wr.idx}] <= wr.data;
		end
		rdata_q <= mem[{rd_slot_q, rd.idx}];
	end

`ifndef ASSERT_OFF
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= mhe_pkg::SLOTS_FULL)
		else $error("block queue count out of range");
	a_no_commit_full: assert property (@(posedge clk) disable iff (!arst_n)
		wr.commit |-> count_q != mhe_pkg::SLOTS_FULL)
		else $error("block committed into full queue");
	a_no_write_full: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> count_q != mhe_pkg::SLOTS_FULL)
		else $error("word written while queue full");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rd.pop |-> count_q != 2'd0)
		else $error("block popped from empty queue");
`endif

endmodule

// ----- sv/mhe_back.sv -----
module mhe_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mhe_pkg::q_stat_t      stat,
	output mhe_pkg::q_rd_t        rd,
	input  logic [31:0]           rdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [31:0]           m_tdata,   // [31:0] digest_word
	output logic [1:0]            m_tuser,   // [1:0] word_number
	output logic                  m_tlast    // last_word
);

	typedef enum logic [2:0] {
		B_IDLE,
		B_PRIME,
		B_RUN,
		B_ADD,
		B_EMIT
	} b_state_t;

	b_state_t     state_q;
	logic [5:0]   step_q;
	logic [1:0]   word_q;
	logic [31:0]  chain_a_q, chain_b_q, chain_c_q, chain_d_q;
	logic [31:0]  a_q, b_q, c_q, d_q;

	logic [31:0]  f;
	logic [31:0]  sum;
	logic [31:0]  b_next;
	logic         out_fire;

	always_comb begin
		case (step_q[5:4])
			2'd0: f = (b_q & c_q) | (~b_q & d_q);
			2'd1: f = (b_q & d_q) | (c_q & ~d_q);
			2'd2: f = b_q ^ c_q ^ d_q;
			2'd3: f = c_q ^ (b_q | ~d_q);
			default: f = '0;
		endcase
	end

	assign sum    = a_q + f + mhe_pkg::k_const(step_q) + rdata;
	assign b_next = b_q + mhe_pkg::rotl32(sum, mhe_pkg::rot_amt(step_q));

	// fetch one step ahead: read data is registered in the queue
	assign rd.idx = (state_q == B_RUN) ? mhe_pkg::msg_idx(step_q + 6'd1)
	                                   : mhe_pkg::msg_idx(6'd0);
	assign rd.pop = (state_q == B_ADD);

	assign m_tvalid = (state_q == B_EMIT);
	assign m_tuser  = word_q;
	assign m_tlast  = (word_q == 2'd3);
	assign out_fire = m_tvalid && m_tready;

	always_comb begin
		case (word_q)
			2'd0: m_tdata = chain_a_q;
			2'd1: m_tdata = chain_b_q;
			2'd2: m_tdata = chain_c_q;
			2'd3: m_tdata = chain_d_q;
			default: m_tdata = chain_a_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			step_q    <= 6'd0;
			word_q    <= 2'd0;
			chain_a_q <= mhe_pkg::INIT_A;
			chain_b_q <= mhe_pkg::INIT_B;
			chain_c_q <= mhe_pkg::INIT_C;
			chain_d_q <= mhe_pkg::INIT_D;
		end else begin
			case (state_q)
				B_IDLE: begin
					if (stat.avail) begin
						step_q  <= 6'd0;
						state_q <= B_PRIME;
					end
				end
				B_PRIME: begin
					state_q <= B_RUN;
				end
				B_RUN: begin
					step_q <= step_q + 6'd1;
					if (step_q == 6'd63) begin
						state_q <= B_ADD;
					end
				end
				B_ADD: begin
					chain_a_q <= chain_a_q + a_q;
					chain_b_q <= chain_b_q + b_q;
					chain_c_q <= chain_c_q + c_q;
					chain_d_q <= chain_d_q + d_q;
					word_q    <= 2'd0;
					state_q   <= stat.head_last ? B_EMIT : B_IDLE;
				end
				B_EMIT: begin
					if (out_fire) begin
						word_q <= word_q + 2'd1;
						// digest delivered: restart chaining for the next message
						if (word_q == 2'd3) begin
							chain_a_q <= mhe_pkg::INIT_A;
							chain_b_q <= mhe_pkg::INIT_B;
							chain_c_q <= mhe_pkg::INIT_C;
							chain_d_q <= mhe_pkg::INIT_D;
							state_q   <= B_IDLE;
						end
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == B_IDLE) begin
			a_q <= chain_a_q;
			b_q <= chain_b_q;
			c_q <= chain_c_q;
			d_q <= chain_d_q;
		end else if (state_q == B_RUN) begin
			a_q <= d_q;
			b_q <= b_next;
			c_q <= b_q;
			d_q <= c_q;
		end
	end

`ifndef ASSERT_OFF
	a_emit_only_after_final: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == B_ADD) && $past(stat.head_last))
		else $error("digest emitted without a closing block");
	a_emit_holds_word: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled digest word changed");
	a_pop_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		rd.pop |-> $past(state_q == B_RUN) && $past(step_q == 6'd63))
		else $error("block released before all rounds ran");
`endif

endmodule

// ----- sv/md5_hash_engine.sv -----
// MD5 hash engine.
// Input stream (s_*): one request per cycle at most. s_tdata carries a message
// byte, s_tuser flags that the byte is present, s_tlast ends the message. A
// request with s_tlast and no byte finishes the message as it stands, so an
// empty message gives the digest of no bytes.
// Output stream (m_*): four words per message, A, B, C, D in that order;
// m_tuser gives the word number and m_tlast marks word D. Digest bytes are
// each word's bytes, low byte first.
// Throughput: one byte per cycle while a block slot is free. Full 64-byte
// blocks go to a two-slot queue; the compressor runs one round per cycle, in
// a start step, a fetch step, 64 rounds and a chaining add per block, and so
// sets the sustained rate near one byte per cycle.
// End of message: padding and the length field are packed one byte per cycle
// while a slot is free (9 to 72 bytes, no input taken), then the last block or
// two are compressed and the digest follows once the final block is done.
// Backpressure on m_tready holds the compressor; the packer keeps taking
// bytes until both queue slots are full, then drops s_tready.
// Reset: arst_n clears position, bit count and queue, and loads the standard
// initial chaining values; no clearing pass is needed.
module md5_hash_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] byte_present
	input  logic        s_tlast,   // end_of_message
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] digest_word
	output logic [1:0]  m_tuser,   // [1:0] word_number
	output logic        m_tlast    // last_word
);

	mhe_pkg::q_wr_t   wr;
	mhe_pkg::q_rd_t   rd;
	mhe_pkg::q_stat_t stat;
	logic [31:0]      rdata;

	mhe_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.stat     (stat),
		.wr       (wr)
	);

	mhe_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.rd     (rd),
		.stat   (stat),
		.rdata  (rdata)
	);

	mhe_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.stat     (stat),
		.rd       (rd),
		.rdata    (rdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
